// ===== rtl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg: shared constants and types of the vector normalizer
// Widths of the component, root, remainder and quotient paths, plus the
// structs that travel down the pipeline.
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int COMPONENT_BITS = 32;
    localparam int CB             = COMPONENT_BITS;
    localparam int OUT_W          = 32;
    localparam int OUT_FRAC       = 30;
    localparam int IN_FRAC        = 16;
    localparam int PT_SHIFT       = OUT_FRAC - IN_FRAC;

    // Sum of three squares of magnitudes up to 2^(CB-1) stays below 2^(2*CB).
    localparam int SUM_W     = 2 * CB;
    localparam int RT_W      = CB + 1;
    localparam int T_W       = 2 * CB + 2;
    localparam int SQ_STAGES = CB + 1;

    // One integer quotient bit and OUT_FRAC fraction bits.
    localparam int Q_W       = OUT_FRAC + 1;
    localparam int DV_STAGES = Q_W;
    localparam int R_W       = CB + 1;

    // Input register, squares, sum, root stages, divider stages.
    localparam int D0     = 3 + SQ_STAGES;
    localparam int N_PIPE = D0 + DV_STAGES;

    typedef struct packed {
        logic [2:0]                neg;
        logic                      unit;
        logic                      zero;
        logic [2:0][CB-1:0]        mag;
        logic [2:0][OUT_W-1:0]     pt;
    } t_side;

    typedef struct packed {
        logic [2:0][OUT_W-1:0]     comp;
        logic                      zero;
    } t_result;

endpackage

// ===== rtl/vector3_normalize_top.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_top: fixed-point 3D vector normalizer
// Takes a Q15.16 vector, returns it scaled to unit length in Q1.30.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid / o_stall) carries x, y, z and an already-unit
// flag; a transfer happens on a rising edge with valid high and stall low.
// The output channel (o_valid / i_stall) carries the three normalized
// components and a flag for a zero-length vector.
// Throughput is one vector per cycle while o_stall is low. On the way to
// o_valid, the input register is followed by the three squaring lanes, the sum,
// one stage per root bit, one stage per quotient bit of the divider lanes and
// the output register.
// Reset empties the pipeline and the output; no clearing pass is needed.
// When the receiver stalls, the held result stays on the output, and one
// more result is caught in a skid register while the pipeline keeps moving;
// once the skid register is full, the whole pipeline freezes and o_stall
// rises until the receiver takes a result.
// Vectors flagged as already unit bypass the length and are shifted left by
// 14 with saturation to plus or minus one.
// ----------------------------------------------------------------------------
module vector3_normalize_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [vn_pkg::CB-1:0]  i_in_x,
    input  logic signed [vn_pkg::CB-1:0]  i_in_y,
    input  logic signed [vn_pkg::CB-1:0]  i_in_z,
    input  logic                          i_already_unit,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [vn_pkg::OUT_W-1:0] o_unit_x,
    output logic signed [vn_pkg::OUT_W-1:0] o_unit_y,
    output logic signed [vn_pkg::OUT_W-1:0] o_unit_z,
    output logic                          o_was_zero
);

    localparam int PT_EXT = vn_pkg::CB + vn_pkg::PT_SHIFT + 4;
    localparam logic signed [PT_EXT-1:0] PT_MAX = PT_EXT'(1) <<< vn_pkg::OUT_FRAC;
    localparam logic signed [PT_EXT-1:0] PT_MIN = -PT_MAX;

    logic                      en;
    logic [vn_pkg::N_PIPE-1:0] r_v;
    vn_pkg::t_side             r_side [vn_pkg::N_PIPE];
    logic [vn_pkg::SUM_W-1:0]  r_sq   [3];
    logic [vn_pkg::SUM_W-1:0]  r_sum;
    logic [vn_pkg::RT_W-1:0]   root;
    logic [vn_pkg::Q_W-1:0]    quo    [3];
    vn_pkg::t_side             n_side0;
    vn_pkg::t_result           n_res;
    vn_pkg::t_result           r_out;
    vn_pkg::t_result           r_skid;
    logic                      r_ov;
    logic                      r_sv;
    logic                      take;
    logic                      pipe_out;

    // Saturating .16 to .30 conversion for pre-normalized input.
    function automatic logic [vn_pkg::OUT_W-1:0] pass_conv(logic signed [vn_pkg::CB-1:0] c);
        logic signed [PT_EXT-1:0] sh;
        sh = PT_EXT'(c) <<< vn_pkg::PT_SHIFT;
        if (sh > PT_MAX) begin
            sh = PT_MAX;
        end else if (sh < PT_MIN) begin
            sh = PT_MIN;
        end
        return sh[vn_pkg::OUT_W-1:0];
    endfunction

    function automatic logic [vn_pkg::CB-1:0] mag_of(logic signed [vn_pkg::CB-1:0] c);
        return c[vn_pkg::CB-1] ? vn_pkg::CB'(-c) : vn_pkg::CB'(c);
    endfunction

    always_comb begin
        n_side0.neg    = {i_in_z[vn_pkg::CB-1], i_in_y[vn_pkg::CB-1], i_in_x[vn_pkg::CB-1]};
        n_side0.unit   = i_already_unit;
        n_side0.zero   = 1'b0;
        n_side0.mag[0] = mag_of(i_in_x);
        n_side0.mag[1] = mag_of(i_in_y);
        n_side0.mag[2] = mag_of(i_in_z);
        n_side0.pt[0]  = pass_conv(i_in_x);
        n_side0.pt[1]  = pass_conv(i_in_y);
        n_side0.pt[2]  = pass_conv(i_in_z);
    end

    // The pipeline moves as a whole while the skid register is free.
    assign en      = !r_sv;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[vn_pkg::N_PIPE-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side0;
        end
    end

    genvar k;
    generate
        for (k = 1; k < vn_pkg::N_PIPE; k++) begin : g_side
            if (k == vn_pkg::D0) begin : g_zero
                vn_pkg::t_side side_in;

                // The root is final here, so the zero-length flag joins the side data.
                always_comb begin
                    side_in      = r_side[k-1];
                    side_in.zero = (root == '0);
                end

                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_side[k] <= side_in;
                    end
                end
            end else begin : g_copy
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_side[k] <= r_side[k-1];
                    end
                end
            end
        end

        // Squaring lanes, then the merge into one sum of squares.
        for (k = 0; k < 3; k++) begin : g_sq
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq[k] <= vn_pkg::SUM_W'(r_side[0].mag[k]) * vn_pkg::SUM_W'(r_side[0].mag[k]);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    vn_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r_sum),
        .o_root (root)
    );

    generate
        for (k = 0; k < 3; k++) begin : g_div
            vn_div_lane u_lane (
                .i_clk (i_clk),
                .i_en  (en),
                .i_mag (r_side[vn_pkg::D0-1].mag[k]),
                .i_len (root[vn_pkg::CB-1:0]),
                .o_quo (quo[k])
            );
        end
    endgenerate

    always_comb begin
        vn_pkg::t_side sd;
        logic [vn_pkg::OUT_W-1:0] val;
        sd = r_side[vn_pkg::N_PIPE-1];
        n_res.zero = sd.zero && !sd.unit;
        for (int i = 0; i < 3; i++) begin
            val = vn_pkg::OUT_W'(quo[i]);
            if (sd.unit) begin
                n_res.comp[i] = sd.pt[i];
            end else if (sd.zero) begin
                n_res.comp[i] = '0;
            end else if (sd.neg[i]) begin
                n_res.comp[i] = -val;
            end else begin
                n_res.comp[i] = val;
            end
        end
    end

    assign take     = r_ov && !i_stall;
    assign pipe_out = en && r_v[vn_pkg::N_PIPE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || take) begin
            r_ov <= r_sv || pipe_out;
            r_sv <= 1'b0;
        end else if (pipe_out) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || take) begin
            r_out <= r_sv ? r_skid : n_res;
        end else if (pipe_out) begin
            r_skid <= n_res;
        end
    end

    assign o_valid    = r_ov;
    assign o_unit_x   = r_out.comp[0];
    assign o_unit_y   = r_out.comp[1];
    assign o_unit_z   = r_out.comp[2];
    assign o_was_zero = r_out.zero;

    // A filled skid register always sits behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid register full without a valid output");

    // A result waiting behind a stall is not lost or replaced.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && i_stall) |=> (r_sv && $stable(r_skid)))
        else $error("skid contents changed during a stall");

    // A zero-length vector delivers zero components.
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_zero) |->
            (o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0))
        else $error("zero flag with nonzero components");

    // The pipeline freezes while the skid register is full.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_sv) && $past(i_rst_n)) |-> $stable(r_v))
        else $error("pipeline moved while the skid register was full");

endmodule

// ===== rtl/vn_sqrt.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage, most significant
// bit first. All stages advance together on i_en.
// ----------------------------------------------------------------------------
module vn_sqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [vn_pkg::SUM_W-1:0]   i_sum,
    output logic [vn_pkg::RT_W-1:0]    o_root
);

    logic [vn_pkg::SUM_W-1:0] r_rem  [vn_pkg::SQ_STAGES];
    logic [vn_pkg::RT_W-1:0]  r_root [vn_pkg::SQ_STAGES];

    genvar s;
    generate
        for (s = 0; s < vn_pkg::SQ_STAGES; s++) begin : g_stage
            localparam int B = vn_pkg::CB - s;
            logic [vn_pkg::SUM_W-1:0] rem_in;
            logic [vn_pkg::RT_W-1:0]  root_in;
            logic [vn_pkg::T_W-1:0]   trial;
            logic [vn_pkg::SUM_W-1:0] n_rem;
            logic [vn_pkg::RT_W-1:0]  n_root;

            if (s == 0) begin : g_first
                assign rem_in  = i_sum;
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = r_rem[s-1];
                assign root_in = r_root[s-1];
            end

            // (root + 2^B)^2 - root^2, valid since the bits of root below B are zero.
            always_comb begin
                trial = ({{(vn_pkg::T_W-vn_pkg::RT_W){1'b0}}, root_in} << (B + 1))
                      + ({{(vn_pkg::T_W-1){1'b0}}, 1'b1} << (2 * B));
                if ({2'b00, rem_in} >= trial) begin
                    n_rem  = rem_in - trial[vn_pkg::SUM_W-1:0];
                    n_root = root_in | ({{(vn_pkg::RT_W-1){1'b0}}, 1'b1} << B);
                end else begin
                    n_rem  = rem_in;
                    n_root = root_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s]  <= n_rem;
                    r_root[s] <= n_root;
                end
            end
        end
    endgenerate

    assign o_root = r_root[vn_pkg::SQ_STAGES-1];

endmodule

// ===== rtl/vn_div_lane.sv =====
// ----------------------------------------------------------------------------
// vn_div_lane: pipelined fraction divider for one component
// Computes floor(mag * 2^30 / len) with mag <= len, one quotient bit per
// stage. Three copies run side by side, one per component.
// ----------------------------------------------------------------------------
module vn_div_lane (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [vn_pkg::CB-1:0]    i_mag,
    input  logic [vn_pkg::CB-1:0]    i_len,
    output logic [vn_pkg::Q_W-1:0]   o_quo
);

    logic [vn_pkg::R_W-1:0] r_rem [vn_pkg::DV_STAGES];
    logic [vn_pkg::R_W-1:0] r_len [vn_pkg::DV_STAGES];
    logic [vn_pkg::Q_W-1:0] r_quo [vn_pkg::DV_STAGES];

    genvar s;
    generate
        for (s = 0; s < vn_pkg::DV_STAGES; s++) begin : g_stage
            logic [vn_pkg::R_W-1:0] rem_sh;
            logic [vn_pkg::R_W-1:0] len_in;
            logic [vn_pkg::Q_W-1:0] quo_sh;
            logic [vn_pkg::R_W-1:0] n_rem;
            logic [vn_pkg::Q_W-1:0] n_quo;

            if (s == 0) begin : g_first
                assign rem_sh = {1'b0, i_mag};
                assign len_in = {1'b0, i_len};
                assign quo_sh = '0;
            end else begin : g_next
                // The remainder stays below len < 2^CB, so the shift cannot overflow.
                assign rem_sh = r_rem[s-1] << 1;
                assign len_in = r_len[s-1];
                assign quo_sh = r_quo[s-1] << 1;
            end

            always_comb begin
                if (rem_sh >= len_in) begin
                    n_rem = rem_sh - len_in;
                    n_quo = quo_sh | {{(vn_pkg::Q_W-1){1'b0}}, 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = quo_sh;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_len[s] <= len_in;
                    r_quo[s] <= n_quo;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[vn_pkg::DV_STAGES-1];

endmodule
